[hw/rtl/srv_pkg.sv]
// shared types and fixed-point constants for the refraction pipeline
// no dependencies; every other file of the block imports this package

package srv_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FW        = 20;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int HALF      = 1 << (FRAC_BITS - 1);

   localparam int COS_W   = FRAC_BITS + 1;
   localparam int PROD_W  = 2 * FW;
   localparam int SUM_W   = 2 * FW + 2;
   localparam int DOT_W   = 2 * FRAC_BITS + 2;
   localparam int NUM_W   = 2 * FRAC_BITS + 1;
   localparam int ETA_W   = 31;
   localparam int EE_W    = 2 * ETA_W;
   localparam int CC_W    = 2 * COS_W;
   localparam int E2_W    = 2 * FRAC_BITS + 2;
   localparam int EC_W    = ETA_W + COS_W;
   localparam int ECR_W   = EC_W - FRAC_BITS;
   localparam int CF_W    = ECR_W + 1;
   localparam int P_W     = E2_W + COS_W;
   localparam int PR_W    = P_W - FRAC_BITS;
   localparam int ROOT_W  = FRAC_BITS + 1;
   localparam int SQ_IN_W = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 2;
   localparam int PA_W    = ETA_W + 1 + FW;
   localparam int PB_W    = FW + CF_W;
   localparam int OS_W    = FW + CF_W + 1;
   localparam int OR_W    = OS_W - FRAC_BITS;

   typedef logic signed [FW-1:0] comp_type;

   typedef struct packed {
      logic signed [FW-1:0] incident_x;
      logic signed [FW-1:0] incident_y;
      logic signed [FW-1:0] incident_z;
      logic signed [FW-1:0] normal_x;
      logic signed [FW-1:0] normal_y;
      logic signed [FW-1:0] normal_z;
      logic [FW-1:0]        material_index;
   } req_type;

   typedef struct packed {
      logic signed [FW-1:0] refracted_x;
      logic signed [FW-1:0] refracted_y;
      logic signed [FW-1:0] refracted_z;
      logic                 total_reflection;
   } rsp_type;

   typedef struct packed {
      comp_type [2:0]   iv;
      comp_type [2:0]   nv;
      logic [FW-1:0]    idx;
      logic             interior;
      logic [COS_W-1:0] cosi;
   } geo_type;

   typedef struct packed {
      geo_type          geo;
      logic [NUM_W-1:0] quo;
   } quo_type;

   typedef struct packed {
      comp_type [2:0]   iv;
      comp_type [2:0]   nv;
      logic             interior;
      logic [ETA_W-1:0] eta;
      logic [ECR_W-1:0] ecr;
      logic             tir;
      logic [COS_W-1:0] kv;
   } kval_type;

   typedef struct packed {
      kval_type          kval;
      logic [ROOT_W-1:0] root;
   } root_type;

endpackage

[hw/rtl/srv_front.sv]
// front stages: component products, dot product clamp, inside test and cosine
// depends on srv_pkg

module srv_front import srv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output geo_type out_data
);

   localparam int S = 3;
   localparam logic signed [SUM_W-1:0] DotMax =
      {{(SUM_W - 2 * FRAC_BITS - 1){1'b0}}, 1'b1, {(2 * FRAC_BITS){1'b0}}};
   localparam logic signed [SUM_W-1:0] DotMin = -DotMax;

   logic [S-1:0] v_ff;
   logic en;
   logic signed [PROD_W-1:0] prod_ff[3];
   logic signed [PROD_W-1:0] prod_in[3];
   logic signed [SUM_W-1:0] sum_in;
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic [DOT_W-1:0] mag, rnd;
   geo_type g0_ff, g0_in, g1_ff, g2_ff, g2_in;

   assign en        = !v_ff[S-1] || !out_stall;
   assign in_stall  = !en;
   assign out_valid = v_ff[S-1];
   assign out_data  = g2_ff;

   always_comb begin
      g0_in = '0;
      g0_in.iv[0] = in_data.incident_x;
      g0_in.iv[1] = in_data.incident_y;
      g0_in.iv[2] = in_data.incident_z;
      g0_in.nv[0] = in_data.normal_x;
      g0_in.nv[1] = in_data.normal_y;
      g0_in.nv[2] = in_data.normal_z;
      g0_in.idx = (in_data.material_index == '0) ? FW'(1) : in_data.material_index;
      prod_in[0] = in_data.incident_x * in_data.normal_x;
      prod_in[1] = in_data.incident_y * in_data.normal_y;
      prod_in[2] = in_data.incident_z * in_data.normal_z;

      sum_in = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
      if (sum_in > DotMax) begin
         dot_in = DotMax[DOT_W-1:0];
      end else if (sum_in < DotMin) begin
         dot_in = DotMin[DOT_W-1:0];
      end else begin
         dot_in = sum_in[DOT_W-1:0];
      end

      mag = dot_ff[DOT_W-1] ? DOT_W'(-dot_ff) : DOT_W'(dot_ff);
      rnd = mag + DOT_W'(HALF);
      g2_in = g1_ff;
      g2_in.interior = (dot_ff > 0);
      g2_in.cosi = rnd[FRAC_BITS +: COS_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[S-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[j] <= prod_in[j];
         end
         g0_ff  <= g0_in;
         dot_ff <= dot_in;
         g1_ff  <= g0_ff;
         g2_ff  <= g2_in;
      end
   end

endmodule

[hw/rtl/srv_div.sv]
// pipelined restoring divider for the reciprocal of the index, one quotient bit a stage
// depends on srv_pkg

module srv_div import srv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  geo_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output quo_type out_data
);

   localparam int S = NUM_W;

   logic [S-1:0] v_ff;
   logic en;
   logic [FW-1:0] rem_ff[S];
   logic [FW-1:0] rem_in[S];
   logic [FW-1:0] rem_src[S];
   logic [FW-1:0] den_src[S];
   logic [NUM_W-1:0] num_ff[S];
   logic [NUM_W-1:0] num_in[S];
   logic [NUM_W-1:0] num_src[S];
   logic [FW:0] part[S];
   logic [FW:0] diff[S];
   logic [NUM_W-1:0] start_num;
   geo_type geo_ff[S];

   assign en        = !v_ff[S-1] || !out_stall;
   assign in_stall  = !en;
   assign out_valid = v_ff[S-1];
   assign out_data  = '{geo: geo_ff[S-1], quo: num_ff[S-1]};

   // dividend is one squared plus half the divisor
   assign start_num = {1'b1, {(NUM_W - 1){1'b0}}} + NUM_W'(in_data.idx >> 1);

   always_comb begin
      rem_src[0] = '0;
      num_src[0] = start_num;
      den_src[0] = in_data.idx;
      for (int i = 1; i < S; i++) begin
         rem_src[i] = rem_ff[i-1];
         num_src[i] = num_ff[i-1];
         den_src[i] = geo_ff[i-1].idx;
      end
      for (int i = 0; i < S; i++) begin
         part[i] = {rem_src[i], num_src[i][NUM_W-1]};
         diff[i] = part[i] - {1'b0, den_src[i]};
         if (part[i] >= {1'b0, den_src[i]}) begin
            rem_in[i] = diff[i][FW-1:0];
            num_in[i] = {num_src[i][NUM_W-2:0], 1'b1};
         end else begin
            rem_in[i] = part[i][FW-1:0];
            num_in[i] = {num_src[i][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[S-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geo_ff[0] <= in_data;
         for (int i = 1; i < S; i++) begin
            geo_ff[i] <= geo_ff[i-1];
         end
         for (int i = 0; i < S; i++) begin
            rem_ff[i] <= rem_in[i];
            num_ff[i] <= num_in[i];
         end
      end
   end

endmodule

[hw/rtl/srv_mid.sv]
// middle stages: eta select, squares, k and total internal reflection test
// depends on srv_pkg

module srv_mid import srv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  quo_type  in_data,
   output logic     out_valid,
   input  logic     out_stall,
   output kval_type out_data
);

   localparam int S = 5;
   localparam logic [E2_W-1:0] E2Lim = {1'b1, {(E2_W - 1){1'b0}}};

   logic [S-1:0] v_ff;
   logic en;
   logic [ETA_W-1:0] eta_in, eta0_ff, eta1_ff;
   geo_type g0_ff, g1_ff;
   logic [EE_W-1:0] ee_ff, ee_r;
   logic [CC_W-1:0] cc_ff, cc_r;
   logic [EC_W-1:0] ec_ff, ec_r;
   logic [EE_W-FRAC_BITS-1:0] e2_full;
   logic [E2_W-1:0] e2_ff, e2_in;
   logic [COS_W-1:0] c2, omc_ff, omc_in;
   logic [P_W-1:0] p_ff, p_r;
   logic [PR_W-1:0] pr, kdiff;
   kval_type k2_ff, k2_in, k3_ff, k4_ff, k4_in;

   assign en        = !v_ff[S-1] || !out_stall;
   assign in_stall  = !en;
   assign out_valid = v_ff[S-1];
   assign out_data  = k4_ff;

   always_comb begin
      if (in_data.geo.interior) begin
         eta_in = ETA_W'(in_data.geo.idx);
      end else if (|in_data.quo[NUM_W-1:ETA_W]) begin
         eta_in = '1;
      end else begin
         eta_in = in_data.quo[ETA_W-1:0];
      end

      ee_r = ee_ff + EE_W'(HALF);
      e2_full = ee_r[EE_W-1:FRAC_BITS];
      e2_in = (e2_full > (EE_W - FRAC_BITS)'(E2Lim)) ? E2Lim : e2_full[E2_W-1:0];
      cc_r = cc_ff + CC_W'(HALF);
      c2 = cc_r[FRAC_BITS +: COS_W];
      omc_in = COS_W'(ONE) - c2;
      ec_r = ec_ff + EC_W'(HALF);
      k2_in = '0;
      k2_in.iv = g1_ff.iv;
      k2_in.nv = g1_ff.nv;
      k2_in.interior = g1_ff.interior;
      k2_in.eta = eta1_ff;
      k2_in.ecr = ec_r[EC_W-1:FRAC_BITS];

      p_r = p_ff + P_W'(HALF);
      pr = p_r[P_W-1:FRAC_BITS];
      kdiff = PR_W'(ONE) - pr;
      k4_in = k3_ff;
      k4_in.tir = (pr > PR_W'(ONE));
      k4_in.kv = k4_in.tir ? '0 : kdiff[COS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[S-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         eta0_ff <= eta_in;
         g0_ff   <= in_data.geo;
         ee_ff   <= eta0_ff * eta0_ff;
         cc_ff   <= g0_ff.cosi * g0_ff.cosi;
         ec_ff   <= eta0_ff * g0_ff.cosi;
         eta1_ff <= eta0_ff;
         g1_ff   <= g0_ff;
         e2_ff   <= e2_in;
         omc_ff  <= omc_in;
         k2_ff   <= k2_in;
         p_ff    <= e2_ff * omc_ff;
         k3_ff   <= k2_ff;
         k4_ff   <= k4_in;
      end
   end

endmodule

[hw/rtl/srv_sqrt.sv]
// pipelined digit-by-digit integer square root of k, one root bit a stage
// depends on srv_pkg

module srv_sqrt import srv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  kval_type in_data,
   output logic     out_valid,
   input  logic     out_stall,
   output root_type out_data
);

   localparam int S = ROOT_W;

   logic [S-1:0] v_ff;
   logic en;
   logic [REM_W-1:0] rem_ff[S];
   logic [REM_W-1:0] rem_in[S];
   logic [REM_W-1:0] rem_src[S];
   logic [ROOT_W-1:0] root_ff[S];
   logic [ROOT_W-1:0] root_in[S];
   logic [ROOT_W-1:0] root_src[S];
   logic [SQ_IN_W-1:0] rad_ff[S];
   logic [SQ_IN_W-1:0] rad_in[S];
   logic [SQ_IN_W-1:0] rad_src[S];
   logic [REM_W+1:0] cur[S];
   logic [REM_W+1:0] trial[S];
   logic [REM_W+1:0] left[S];
   kval_type kv_ff[S];

   assign en        = !v_ff[S-1] || !out_stall;
   assign in_stall  = !en;
   assign out_valid = v_ff[S-1];
   assign out_data  = '{kval: kv_ff[S-1], root: root_ff[S-1]};

   always_comb begin
      rem_src[0]  = '0;
      root_src[0] = '0;
      rad_src[0]  = SQ_IN_W'({in_data.kv, {FRAC_BITS{1'b0}}});
      for (int i = 1; i < S; i++) begin
         rem_src[i]  = rem_ff[i-1];
         root_src[i] = root_ff[i-1];
         rad_src[i]  = rad_ff[i-1];
      end
      for (int i = 0; i < S; i++) begin
         cur[i]   = {rem_src[i], rad_src[i][SQ_IN_W-1 -: 2]};
         trial[i] = {2'b00, root_src[i], 2'b01};
         left[i]  = cur[i] - trial[i];
         rad_in[i] = {rad_src[i][SQ_IN_W-3:0], 2'b00};
         if (cur[i] >= trial[i]) begin
            rem_in[i]  = left[i][REM_W-1:0];
            root_in[i] = {root_src[i][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = cur[i][REM_W-1:0];
            root_in[i] = {root_src[i][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[S-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kv_ff[0] <= in_data;
         for (int i = 1; i < S; i++) begin
            kv_ff[i] <= kv_ff[i-1];
         end
         for (int i = 0; i < S; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            rad_ff[i]  <= rad_in[i];
         end
      end
   end

endmodule

[hw/rtl/srv_back.sv]
// back stages: coefficient, output products, rounding and saturation
// depends on srv_pkg

module srv_back import srv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  root_type in_data,
   output logic     out_valid,
   input  logic     out_stall,
   output rsp_type  out_data
);

   localparam int S = 4;
   localparam logic signed [OR_W-1:0] FieldMax = OR_W'((1 << (FW - 1)) - 1);
   localparam logic signed [OR_W-1:0] FieldMin = -FieldMax - OR_W'(1);

   logic [S-1:0] v_ff;
   logic en;
   logic [S-2:0] tir_ff;
   logic signed [CF_W-1:0] coef, coef_in, coef_ff;
   logic [ETA_W-1:0] eta_ff;
   comp_type [2:0] iv_ff, nv_ff;
   logic signed [PA_W-1:0] pa_ff[3];
   logic signed [PB_W-1:0] pb_ff[3];
   logic signed [OS_W-1:0] s_ff[3];
   logic signed [OS_W-1:0] r[3];
   logic signed [OR_W-1:0] q[3];
   logic signed [FW-1:0] sat[3];
   rsp_type out_ff, out_in;

   assign en        = !v_ff[S-1] || !out_stall;
   assign in_stall  = !en;
   assign out_valid = v_ff[S-1];
   assign out_data  = out_ff;

   always_comb begin
      coef = $signed({1'b0, in_data.kval.ecr})
           - $signed({{(CF_W - ROOT_W){1'b0}}, in_data.root});
      // inside the object the normal is flipped
      coef_in = in_data.kval.interior ? -coef : coef;

      for (int j = 0; j < 3; j++) begin
         r[j] = s_ff[j] + (s_ff[j][OS_W-1] ? OS_W'(HALF - 1) : OS_W'(HALF));
         q[j] = r[j][OS_W-1:FRAC_BITS];
         if (q[j] > FieldMax) begin
            sat[j] = FieldMax[FW-1:0];
         end else if (q[j] < FieldMin) begin
            sat[j] = FieldMin[FW-1:0];
         end else begin
            sat[j] = q[j][FW-1:0];
         end
      end
      out_in.total_reflection = tir_ff[S-2];
      out_in.refracted_x = tir_ff[S-2] ? '0 : sat[0];
      out_in.refracted_y = tir_ff[S-2] ? '0 : sat[1];
      out_in.refracted_z = tir_ff[S-2] ? '0 : sat[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[S-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tir_ff  <= {tir_ff[S-3:0], in_data.kval.tir};
         coef_ff <= coef_in;
         eta_ff  <= in_data.kval.eta;
         iv_ff   <= in_data.kval.iv;
         nv_ff   <= in_data.kval.nv;
         for (int j = 0; j < 3; j++) begin
            pa_ff[j] <= $signed({1'b0, eta_ff}) * $signed(iv_ff[j]);
            pb_ff[j] <= $signed(nv_ff[j]) * coef_ff;
            s_ff[j]  <= OS_W'(pa_ff[j]) + OS_W'(pb_ff[j]);
         end
         out_ff <= out_in;
      end
   end

endmodule

[hw/rtl/snell_refraction_vector.sv]
// top level of the refraction direction pipeline
// depends on srv_pkg, srv_front, srv_div, srv_mid, srv_sqrt and srv_back
//
// Usage
//   req channel: incident vector, surface normal and index (signed and unsigned
//   Q4.16) move on a transfer when req_valid is high and req_stall is low.
//   rsp channel: refracted vector and total_reflection flag, same handshake,
//   with rsp_stall driven by the receiver.
//   From req transfer to rsp_valid an item passes 3 front stages,
//   33 divider stages (one quotient bit each for the reciprocal of the index),
//   5 stages for the squares and k, 17 square root stages (one root bit each)
//   and 4 back stages ending in the output register.
//   Throughput is one item per cycle unless stalled; every stage is fully pipelined.
//   When the receiver stalls with a result waiting, each pipeline section with
//   a valid item at its end holds; req_stall rises once the hold reaches the
//   front section. No item is lost or repeated, and sections whose last stage
//   is empty keep moving.
//   Reset clears all valid bits; the data registers are not reset.

module snell_refraction_vector import srv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic f_valid, f_stall, d_valid, d_stall, m_valid, m_stall, s_valid, s_stall;
   geo_type  f_data;
   quo_type  d_data;
   kval_type m_data;
   root_type s_data;

   srv_front u_front (
      .clock, .reset,
      .in_valid (req_valid), .in_stall (req_stall), .in_data (req_data),
      .out_valid (f_valid), .out_stall (f_stall), .out_data (f_data)
   );

   srv_div u_div (
      .clock, .reset,
      .in_valid (f_valid), .in_stall (f_stall), .in_data (f_data),
      .out_valid (d_valid), .out_stall (d_stall), .out_data (d_data)
   );

   srv_mid u_mid (
      .clock, .reset,
      .in_valid (d_valid), .in_stall (d_stall), .in_data (d_data),
      .out_valid (m_valid), .out_stall (m_stall), .out_data (m_data)
   );

   srv_sqrt u_sqrt (
      .clock, .reset,
      .in_valid (m_valid), .in_stall (m_stall), .in_data (m_data),
      .out_valid (s_valid), .out_stall (s_stall), .out_data (s_data)
   );

   srv_back u_back (
      .clock, .reset,
      .in_valid (s_valid), .in_stall (s_stall), .in_data (s_data),
      .out_valid (rsp_valid), .out_stall (rsp_stall), .out_data (rsp_data)
   );

   a_tir_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.total_reflection |->
         rsp_data.refracted_x == '0 && rsp_data.refracted_y == '0
         && rsp_data.refracted_z == '0)
      else $error("total reflection with non-zero direction");

   a_no_stall_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input held while output side is free");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for snell_refraction_vector
// depends on srv_pkg and the block's rtl; predicts each refracted vector in place
`timescale 1ns / 100ps

module testbench import srv_pkg::*;;

   localparam int LATENCY = 62;
   localparam int WATCHDOG = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_rays[$];
   rsp_type expected_dirs[$];
   int      errors = 0;
   int      idle_cycles = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_off = 1'b0;

   snell_refraction_vector dut (.*);

   always #6 clock = ~clock;

   function automatic longint round_shift(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint floor_root(longint v);
      longint r;
      r = longint'($sqrt(real'(v)));
      while (r * r > v) r--;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic comp_type clip(longint v);
      if (v > 524287) return comp_type'(524287);
      if (v < -524288) return comp_type'(-524288);
      return comp_type'(v);
   endfunction

   function automatic rsp_type refract(req_type r);
      longint one, one2, d, cosi, c2, eta, eta2, k, sk, coef, idx;
      longint iv[3], nv[3];
      rsp_type o;
      one = 64'sd1 <<< FRAC_BITS;
      one2 = one <<< FRAC_BITS;
      iv[0] = r.incident_x; iv[1] = r.incident_y; iv[2] = r.incident_z;
      nv[0] = r.normal_x; nv[1] = r.normal_y; nv[2] = r.normal_z;
      idx = r.material_index;
      if (idx == 0) idx = 1;
      d = iv[0] * nv[0] + iv[1] * nv[1] + iv[2] * nv[2];
      if (d > one2) d = one2;
      if (d < -one2) d = -one2;
      cosi = round_shift(-d);
      if (d > 0) begin
         cosi = -cosi;
         for (int j = 0; j < 3; j++) nv[j] = -nv[j];
         eta = idx;
      end else begin
         eta = (one2 + (idx >>> 1)) / idx;
      end
      if (eta > 64'sd2147483647) eta = 64'sd2147483647;
      c2 = round_shift(cosi * cosi);
      eta2 = round_shift(eta * eta);
      k = one - round_shift(eta2 * (one - c2));
      o = '0;
      if (k < 0) begin
         o.total_reflection = 1'b1;
         return o;
      end
      sk = floor_root(k <<< FRAC_BITS);
      coef = round_shift(eta * cosi) - sk;
      o.refracted_x = clip(round_shift(eta * iv[0] + nv[0] * coef));
      o.refracted_y = clip(round_shift(eta * iv[1] + nv[1] * coef));
      o.refracted_z = clip(round_shift(eta * iv[2] + nv[2] * coef));
      return o;
   endfunction

   function automatic comp_type any_comp();
      case ($urandom_range(0, 5))
         0: return comp_type'($urandom);
         1: return comp_type'(524287);
         2: return comp_type'(-524288);
         default: return comp_type'($signed($urandom_range(0, 2 * ONE)) - ONE);
      endcase
   endfunction

   function automatic req_type ray(int ix, int iy, int iz, int nx, int ny, int nz, int m);
      req_type r;
      r.incident_x = comp_type'(ix); r.incident_y = comp_type'(iy);
      r.incident_z = comp_type'(iz);
      r.normal_x = comp_type'(nx); r.normal_y = comp_type'(ny);
      r.normal_z = comp_type'(nz);
      r.material_index = FW'(m);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_rays.size() > 0 && !hold_off &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_data <= pending_rays.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // monitor and predictor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) expected_dirs.push_back(refract(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_dirs.size() == 0) begin
               $display("%0t unexpected transfer %h", $time, rsp_data);
               errors++;
            end else begin
               want = expected_dirs.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t mismatch expected %h actual %h", $time, want, rsp_data);
                  errors++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_rays.size() > 0 || req_valid || expected_dirs.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      req_type r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      pending_rays.push_back(ray(0, -ONE, 0, 0, ONE, 0, ONE));
      pending_rays.push_back(ray(0, -ONE, 0, 0, ONE, 0, ONE + ONE / 2));
      pending_rays.push_back(ray(0, ONE, 0, 0, ONE, 0, ONE + ONE / 2));
      pending_rays.push_back(ray(46341, -46341, 0, 0, ONE, 0, ONE / 2));
      pending_rays.push_back(ray(46341, 46341, 0, 0, ONE, 0, 2 * ONE));
      pending_rays.push_back(ray(0, -ONE, 0, 0, ONE, 0, 0));
      pending_rays.push_back(ray(0, -ONE, 0, 0, ONE, 0, 1));
      pending_rays.push_back(ray(0, -ONE, 0, 0, ONE, 0, 1048575));
      pending_rays.push_back(ray(524287, 524287, 524287, 524287, 524287, 524287, 1048575));
      pending_rays.push_back(ray(-524288, -524288, -524288, 524287, 524287, 524287, 7));
      pending_rays.push_back(ray(-524288, -524288, -524288, -524288, -524288, -524288, 1));
      pending_rays.push_back(ray(0, 0, 0, 0, 0, 0, ONE));
      pending_rays.push_back(ray(3 * ONE, -2 * ONE, ONE, -ONE, 2 * ONE, 0, ONE / 3));
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 88 : 0;
         recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 7 : 0;
         for (int n = 0; n < 530; n++) begin
            r.incident_x = any_comp(); r.incident_y = any_comp(); r.incident_z = any_comp();
            r.normal_x = any_comp(); r.normal_y = any_comp(); r.normal_z = any_comp();
            case ($urandom_range(0, 3))
               0: r.material_index = FW'($urandom);
               1: r.material_index = FW'($urandom_range(0, 3));
               default: r.material_index = FW'($urandom_range(ONE / 2, 3 * ONE));
            endcase
            pending_rays.push_back(r);
         end
         if (phase == 0) begin
            while (pending_rays.size() > 265) @(posedge clock);
            hold_off = 1'b1;
            while (req_valid || expected_dirs.size() > 0) @(posedge clock);
            hold_off = 1'b0;
         end
         drain();
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && expected_dirs.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
